// ===== rtl/rtp_header_parser_macros.svh =====
// Assertion helpers shared by the parser RTL.
// Each use expands to one labeled concurrent assertion clocked on aclk,
// disabled while aresetn is low.
`ifndef RTP_HEADER_PARSER_MACROS_SVH
`define RTP_HEADER_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTP_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rtp_pkg.sv =====
`timescale 1ns / 1ps

package rtp_pkg;

    localparam logic [2:0] KIND_HEADER  = 3'd0;
    localparam logic [2:0] KIND_CSRC    = 3'd1;
    localparam logic [2:0] KIND_EXT_HDR = 3'd2;
    localparam logic [2:0] KIND_EXT_WORD = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT     = 2'd1;
    localparam logic [1:0] STATUS_BAD_PAD   = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

    localparam int HDR_BYTES  = 12;
    localparam int HDR_HIGH_BYTES = 8;

    // queue between parser front and output back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  version;
        logic        has_padding;
        logic        has_extension;
        logic [3:0]  csrc_count;
        logic        marker;
        logic [6:0]  payload_type;
        logic [15:0] sequence_number;
        logic [31:0] time_stamp;
        logic [31:0] sync_source;
        logic [31:0] word_value;
        logic [1:0]  status;
    } rtp_result_t;

    // one queue entry: the result a byte produced, plus the end record on the last byte
    typedef struct packed {
        logic        prim_valid;
        rtp_result_t prim;
        logic        end_valid;
        logic [31:0] end_word;
        logic [1:0]  end_status;
    } rtp_entry_t;

endpackage

// ===== rtl/rtp_header_parser.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Payload                                          Handshake
// s_       in         data_byte[7:0], last_byte                        s_valid / s_ready
// m_       out        kind, header fields, word_value, status          m_valid / m_ready
//
// One byte is taken per cycle while s_ready is high and is parsed in the cycle it is taken.
// Results leave through a registered output, one per cycle while m_ready is high;
// a final byte with a primary result yields two and holds its queue slot until both leave.
// A 4-entry queue sits between parser and output stage; s_ready drops only when it is full.
// Reset (aresetn low at a clock edge) clears the parser state, the queue and m_valid.

module rtp_header_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic        s_valid,
    output logic        s_ready,

    output logic [2:0]  m_kind,
    output logic [1:0]  m_version,
    output logic        m_has_padding,
    output logic        m_has_extension,
    output logic [3:0]  m_csrc_count,
    output logic        m_marker,
    output logic [6:0]  m_payload_type,
    output logic [15:0] m_sequence_number,
    output logic [31:0] m_time_stamp,
    output logic [31:0] m_sync_source,
    output logic [31:0] m_word_value,
    output logic [1:0]  m_status,
    output logic        m_valid,
    input  logic        m_ready
);

    rtp_pkg::rtp_entry_t  push_entry;
    rtp_pkg::rtp_entry_t  head_entry;
    rtp_pkg::rtp_result_t result;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;

    rtp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .full_i      (full),
        .push_o      (push),
        .entry_o     (push_entry)
    );

    rtp_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_entry),
        .pop     (pop),
        .dout    (head_entry),
        .full    (full),
        .empty   (empty)
    );

    rtp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_entry),
        .empty_i  (empty),
        .pop_o    (pop),
        .m_result (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready)
    );

    assign m_kind            = result.kind;
    assign m_version         = result.version;
    assign m_has_padding     = result.has_padding;
    assign m_has_extension   = result.has_extension;
    assign m_csrc_count      = result.csrc_count;
    assign m_marker          = result.marker;
    assign m_payload_type    = result.payload_type;
    assign m_sequence_number = result.sequence_number;
    assign m_time_stamp      = result.time_stamp;
    assign m_sync_source     = result.sync_source;
    assign m_word_value      = result.word_value;
    assign m_status          = result.status;

endmodule

// ===== rtl/rtp_fifo.sv =====
`timescale 1ns / 1ps
`include "rtp_header_parser_macros.svh"

module rtp_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rtp_pkg::rtp_entry_t din,
    input  logic               pop,
    output rtp_pkg::rtp_entry_t dout,
    output logic               full,
    output logic               empty
);

    rtp_pkg::rtp_entry_t mem [rtp_pkg::FIFO_DEPTH];

    logic [rtp_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rtp_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rtp_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == rtp_pkg::FIFO_CNT_W'(rtp_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `RTP_ASSERT_HOLDS(a_fifo_no_overflow, full, !push, "push into full queue")
    `RTP_ASSERT_HOLDS(a_fifo_no_underflow, empty, !pop, "pop from empty queue")
    `RTP_ASSERT_NEXT(a_fifo_count_up, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count did not advance")

endmodule

// ===== rtl/rtp_front.sv =====
`timescale 1ns / 1ps

module rtp_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_data_byte,
    input  logic               s_last_byte,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               full_i,
    output logic               push_o,
    output rtp_pkg::rtp_entry_t entry_o
);

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_CSRC    = 5'b00010,
        PH_EXTHDR  = 5'b00100,
        PH_EXTDATA = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } rtp_phase_t;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX      = '1;
    localparam logic [LENGTH_BITS-1:0] IDX_HIGH_END = LENGTH_BITS'(rtp_pkg::HDR_HIGH_BYTES);
    localparam logic [LENGTH_BITS-1:0] IDX_HDR_END  = LENGTH_BITS'(rtp_pkg::HDR_BYTES);

    rtp_phase_t              phase_reg, phase_next;
    logic [LENGTH_BITS-1:0]  idx_reg, idx_next;
    logic [63:0]             hh_reg, hh_next;
    logic [31:0]             hl_reg, hl_next;
    logic [3:0]              csrc_reg, csrc_next;
    logic [15:0]             ext_reg, ext_next;
    logic [23:0]             gather_reg, gather_next;
    logic [1:0]              biw_reg, biw_next;
    logic [LENGTH_BITS-1:0]  pc_reg, pc_next;
    logic                    err_reg, err_next;
    logic                    pad_reg, pad_next;

    logic                    accept;
    logic [31:0]             word;
    logic [7:0]              b0;
    logic [7:0]              b1;
    logic [31:0]             pc_wide;
    logic [15:0]             plen;
    logic [7:0]              pad_count;
    logic [1:0]              status;
    rtp_pkg::rtp_result_t    prim;
    logic                    prim_v;

    assign s_ready = !full_i;
    assign accept  = s_valid && s_ready;
    assign word    = {gather_reg, s_data_byte};
    assign b0      = hh_reg[63:56];
    assign b1      = hh_reg[55:48];

    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        hh_next     = hh_reg;
        hl_next     = hl_reg;
        csrc_next   = csrc_reg;
        ext_next    = ext_reg;
        gather_next = gather_reg;
        biw_next    = biw_reg;
        pc_next     = pc_reg;
        err_next    = err_reg;
        pad_next    = pad_reg;
        prim        = '0;
        prim_v      = 1'b0;

        // byte count saturates; a byte past the limit makes the packet too long
        if (idx_reg == LEN_MAX) begin
            err_next = 1'b1;
        end else begin
            idx_next = idx_reg + 1'b1;
        end

        unique case (phase_reg)
            PH_HEADER: begin
                if (idx_next <= IDX_HIGH_END) begin
                    hh_next = {hh_reg[55:0], s_data_byte};
                end else begin
                    hl_next = {hl_reg[23:0], s_data_byte};
                end
                if (idx_next == IDX_HDR_END) begin
                    prim_v               = 1'b1;
                    prim.kind            = rtp_pkg::KIND_HEADER;
                    prim.version         = b0[7:6];
                    prim.has_padding     = b0[5];
                    prim.has_extension   = b0[4];
                    prim.csrc_count      = b0[3:0];
                    prim.marker          = b1[7];
                    prim.payload_type    = b1[6:0];
                    prim.sequence_number = hh_reg[47:32];
                    prim.time_stamp      = hh_reg[31:0];
                    prim.sync_source     = {hl_reg[23:0], s_data_byte};
                    pad_next             = b0[5];
                    csrc_next            = b0[3:0];
                    if (b0[3:0] != 4'd0) begin
                        phase_next = PH_CSRC;
                    end else if (b0[4]) begin
                        phase_next = PH_EXTHDR;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_CSRC, PH_EXTHDR, PH_EXTDATA: begin
                gather_next = word[23:0];
                biw_next    = biw_reg + 1'b1;
                if (biw_reg == 2'd3) begin
                    prim_v          = 1'b1;
                    prim.word_value = word;
                    gather_next     = '0;
                    if (phase_reg == PH_CSRC) begin
                        prim.kind = rtp_pkg::KIND_CSRC;
                        csrc_next = csrc_reg - 1'b1;
                        if (csrc_reg == 4'd1) begin
                            phase_next = b0[4] ? PH_EXTHDR : PH_PAYLOAD;
                        end
                    end else if (phase_reg == PH_EXTHDR) begin
                        prim.kind  = rtp_pkg::KIND_EXT_HDR;
                        ext_next   = word[15:0];
                        phase_next = (word[15:0] != 16'd0) ? PH_EXTDATA : PH_PAYLOAD;
                    end else begin
                        prim.kind = rtp_pkg::KIND_EXT_WORD;
                        ext_next  = ext_reg - 1'b1;
                        if (ext_reg == 16'd1) begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                prim_v          = 1'b1;
                prim.kind       = rtp_pkg::KIND_PAYLOAD;
                prim.word_value = {24'd0, s_data_byte};
                if (pc_reg != LEN_MAX) begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        // end record, from the state as it stands after this byte
        pc_wide   = 32'(pc_next);
        plen      = (pc_wide > 32'h0000_FFFF) ? 16'hFFFF : pc_wide[15:0];
        pad_count = 8'd0;
        if (err_next) begin
            status = rtp_pkg::STATUS_TOO_LONG;
        end else if (phase_next != PH_PAYLOAD) begin
            status = rtp_pkg::STATUS_SHORT;
        end else if (pad_next && (pc_next != '0)) begin
            if ((s_data_byte == 8'd0) || (LENGTH_BITS'(s_data_byte) > pc_next)) begin
                status = rtp_pkg::STATUS_BAD_PAD;
            end else begin
                status    = rtp_pkg::STATUS_OK;
                pad_count = s_data_byte;
            end
        end else begin
            status = rtp_pkg::STATUS_OK;
        end

        if (s_last_byte) begin
            phase_next  = PH_HEADER;
            idx_next    = '0;
            hh_next     = '0;
            hl_next     = '0;
            csrc_next   = '0;
            ext_next    = '0;
            gather_next = '0;
            biw_next    = '0;
            pc_next     = '0;
            err_next    = 1'b0;
            pad_next    = 1'b0;
        end
    end

    assign push_o              = accept && (prim_v || s_last_byte);
    assign entry_o.prim_valid  = prim_v;
    assign entry_o.prim        = prim;
    assign entry_o.end_valid   = s_last_byte;
    assign entry_o.end_word    = {8'd0, pad_count, plen};
    assign entry_o.end_status  = status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            idx_reg    <= '0;
            hh_reg     <= '0;
            hl_reg     <= '0;
            csrc_reg   <= '0;
            ext_reg    <= '0;
            gather_reg <= '0;
            biw_reg    <= '0;
            pc_reg     <= '0;
            err_reg    <= 1'b0;
            pad_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            hh_reg     <= hh_next;
            hl_reg     <= hl_next;
            csrc_reg   <= csrc_next;
            ext_reg    <= ext_next;
            gather_reg <= gather_next;
            biw_reg    <= biw_next;
            pc_reg     <= pc_next;
            err_reg    <= err_next;
            pad_reg    <= pad_next;
        end
    end

endmodule

// ===== rtl/rtp_back.sv =====
`timescale 1ns / 1ps
`include "rtp_header_parser_macros.svh"

module rtp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rtp_pkg::rtp_entry_t  head,
    input  logic                 empty_i,
    output logic                 pop_o,
    output rtp_pkg::rtp_result_t m_result,
    output logic                 m_valid,
    input  logic                 m_ready
);

    rtp_pkg::rtp_result_t out_reg, out_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 prim_done_reg, prim_done_next;

    logic                 load;
    logic                 take;
    logic                 sel_prim;
    rtp_pkg::rtp_result_t end_res;

    assign load     = !m_valid_reg || m_ready;
    assign take     = load && !empty_i;
    // an entry goes out as its primary result first, then its end record
    assign sel_prim = head.prim_valid && !prim_done_reg;
    assign pop_o    = take && (!sel_prim || !head.end_valid);

    always_comb begin
        end_res            = '0;
        end_res.kind       = rtp_pkg::KIND_END;
        end_res.word_value = head.end_word;
        end_res.status     = head.end_status;

        out_next       = out_reg;
        m_valid_next   = m_valid_reg;
        prim_done_next = prim_done_reg;
        if (load) begin
            m_valid_next = !empty_i;
        end
        if (take) begin
            out_next       = sel_prim ? head.prim : end_res;
            prim_done_next = !pop_o;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            prim_done_reg <= 1'b0;
        end else begin
            m_valid_reg   <= m_valid_next;
            prim_done_reg <= prim_done_next;
        end
    end

    assign m_result = out_reg;
    assign m_valid  = m_valid_reg;

    `RTP_ASSERT_HOLDS(a_back_entry_nonempty, !empty_i, head.prim_valid || head.end_valid,
        "queue entry carries no result")
    `RTP_ASSERT_HOLDS(a_back_split_pending, prim_done_reg, !empty_i && head.end_valid,
        "end record lost after primary result")
    `RTP_ASSERT_NEXT(a_back_hold_output, m_valid_reg && !m_ready,
        m_valid_reg && (out_reg == $past(out_reg)), "output changed while stalled")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    typedef enum logic [4:0] {
        PH_FIXED     = 5'b00001,
        PH_CSRC_LIST = 5'b00010,
        PH_EXT_HEAD  = 5'b00100,
        PH_EXT_WORDS = 5'b01000,
        PH_BODY      = 5'b10000
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  m_kind;
    logic [1:0]  m_version;
    logic        m_has_padding;
    logic        m_has_extension;
    logic [3:0]  m_csrc_count;
    logic        m_marker;
    logic [6:0]  m_payload_type;
    logic [15:0] m_sequence_number;
    logic [31:0] m_time_stamp;
    logic [31:0] m_sync_source;
    logic [31:0] m_word_value;
    logic [1:0]  m_status;
    logic        m_valid;
    logic        m_ready = 1'b0;

    wire_byte_t           byte_queue[$];
    rtp_pkg::rtp_result_t result_queue[$];
    logic [7:0]           pkt_build[$];

    int unsigned bytes_sent = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;
    int unsigned hold_token = 0;
    int unsigned hold_seen = 0;
    int unsigned src_wait = 0;
    int unsigned sink_wait = 0;
    logic        in_fire = 1'b0;

    // parser mirror
    parse_phase_t        phase;
    logic [LEN_BITS-1:0] pkt_bytes;
    logic [63:0]         hdr_high;
    logic [31:0]         hdr_low;
    logic [3:0]          csrc_remaining;
    logic [15:0]         ext_remaining;
    logic [31:0]         gather_word;
    logic [1:0]          gather_pos;
    logic [LEN_BITS-1:0] body_count;
    logic [7:0]          final_byte;
    logic [1:0]          err_code;
    logic                pad_flag;

    rtp_header_parser #(
        .LENGTH_BITS(LEN_BITS)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .m_kind           (m_kind),
        .m_version        (m_version),
        .m_has_padding    (m_has_padding),
        .m_has_extension  (m_has_extension),
        .m_csrc_count     (m_csrc_count),
        .m_marker         (m_marker),
        .m_payload_type   (m_payload_type),
        .m_sequence_number(m_sequence_number),
        .m_time_stamp     (m_time_stamp),
        .m_sync_source    (m_sync_source),
        .m_word_value     (m_word_value),
        .m_status         (m_status),
        .m_valid          (m_valid),
        .m_ready          (m_ready)
    );

    always #6 aclk = ~aclk;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic rtp_pkg::rtp_result_t plain_result(logic [2:0] kind, logic [31:0] word,
                                                          logic [1:0] status);
        rtp_pkg::rtp_result_t r;
        r = '0;
        r.kind = kind;
        r.word_value = word;
        r.status = status;
        return r;
    endfunction

    function automatic parse_phase_t after_csrc();
        return hdr_high[60] ? PH_EXT_HEAD : PH_BODY;
    endfunction

    task automatic expect_result(input rtp_pkg::rtp_result_t r);
        result_queue = {result_queue, r};
    endtask

    task automatic append_byte(input logic [7:0] v);
        pkt_build = {pkt_build, v};
    endtask

    task automatic clear_packet();
        phase = PH_FIXED;
        pkt_bytes = '0;
        hdr_high = '0;
        hdr_low = '0;
        csrc_remaining = '0;
        ext_remaining = '0;
        gather_word = '0;
        gather_pos = '0;
        body_count = '0;
        err_code = rtp_pkg::STATUS_OK;
        pad_flag = 1'b0;
    endtask

    // Works out the results one accepted byte causes and queues them.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        rtp_pkg::rtp_result_t r;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [1:0]  st;
        logic [7:0]  pad;
        logic [31:0] cnt32;
        logic [15:0] plen;
        final_byte = b;
        if (pkt_bytes == LEN_MAX) err_code = rtp_pkg::STATUS_TOO_LONG;
        else pkt_bytes = pkt_bytes + 1'b1;

        case (phase)
            PH_FIXED: begin
                if (pkt_bytes <= rtp_pkg::HDR_HIGH_BYTES) hdr_high = {hdr_high[55:0], b};
                else hdr_low = {hdr_low[23:0], b};
                if (pkt_bytes == rtp_pkg::HDR_BYTES) begin
                    b0 = hdr_high[63:56];
                    b1 = hdr_high[55:48];
                    r = plain_result(rtp_pkg::KIND_HEADER, '0, rtp_pkg::STATUS_OK);
                    r.version = b0[7:6];
                    r.has_padding = b0[5];
                    r.has_extension = b0[4];
                    r.csrc_count = b0[3:0];
                    r.marker = b1[7];
                    r.payload_type = b1[6:0];
                    r.sequence_number = hdr_high[47:32];
                    r.time_stamp = hdr_high[31:0];
                    r.sync_source = hdr_low;
                    expect_result(r);
                    pad_flag = b0[5];
                    csrc_remaining = b0[3:0];
                    phase = (csrc_remaining != 0) ? PH_CSRC_LIST : after_csrc();
                end
            end
            PH_CSRC_LIST, PH_EXT_HEAD, PH_EXT_WORDS: begin
                gather_word = {gather_word[23:0], b};
                gather_pos = gather_pos + 1'b1;
                if (gather_pos == 0) begin
                    if (phase == PH_CSRC_LIST) begin
                        expect_result(plain_result(rtp_pkg::KIND_CSRC, gather_word,
                                                   rtp_pkg::STATUS_OK));
                        csrc_remaining = csrc_remaining - 1'b1;
                        if (csrc_remaining == 0) phase = after_csrc();
                    end else if (phase == PH_EXT_HEAD) begin
                        expect_result(plain_result(rtp_pkg::KIND_EXT_HDR, gather_word,
                                                   rtp_pkg::STATUS_OK));
                        ext_remaining = gather_word[15:0];
                        phase = (ext_remaining != 0) ? PH_EXT_WORDS : PH_BODY;
                    end else begin
                        expect_result(plain_result(rtp_pkg::KIND_EXT_WORD, gather_word,
                                                   rtp_pkg::STATUS_OK));
                        ext_remaining = ext_remaining - 1'b1;
                        if (ext_remaining == 0) phase = PH_BODY;
                    end
                    gather_word = '0;
                end
            end
            PH_BODY: begin
                expect_result(plain_result(rtp_pkg::KIND_PAYLOAD, {24'h0, b},
                                           rtp_pkg::STATUS_OK));
                if (body_count != LEN_MAX) body_count = body_count + 1'b1;
            end
            default: phase = PH_FIXED;
        endcase

        if (last) begin
            st = rtp_pkg::STATUS_OK;
            pad = '0;
            cnt32 = 32'(body_count);
            plen = (cnt32 > 32'h0000_FFFF) ? 16'hFFFF : cnt32[15:0];
            if (err_code == rtp_pkg::STATUS_TOO_LONG) begin
                st = rtp_pkg::STATUS_TOO_LONG;
            end else if (phase != PH_BODY) begin
                st = rtp_pkg::STATUS_SHORT;
            end else if (pad_flag && body_count != 0) begin
                if (final_byte == 0 || final_byte > body_count) st = rtp_pkg::STATUS_BAD_PAD;
                else pad = final_byte;
            end
            expect_result(plain_result(rtp_pkg::KIND_END, {8'h0, pad, plen}, st));
            clear_packet();
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got,
                 want);
        err_count++;
    endtask

    task automatic check_result(input rtp_pkg::rtp_result_t got);
        rtp_pkg::rtp_result_t want;
        want = result_queue.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.version !== want.version)
            report_mismatch("version", 32'(got.version), 32'(want.version));
        if (got.has_padding !== want.has_padding)
            report_mismatch("has_padding", 32'(got.has_padding), 32'(want.has_padding));
        if (got.has_extension !== want.has_extension)
            report_mismatch("has_extension", 32'(got.has_extension), 32'(want.has_extension));
        if (got.csrc_count !== want.csrc_count)
            report_mismatch("csrc_count", 32'(got.csrc_count), 32'(want.csrc_count));
        if (got.marker !== want.marker)
            report_mismatch("marker", 32'(got.marker), 32'(want.marker));
        if (got.payload_type !== want.payload_type)
            report_mismatch("payload_type", 32'(got.payload_type), 32'(want.payload_type));
        if (got.sequence_number !== want.sequence_number)
            report_mismatch("sequence_number", 32'(got.sequence_number),
                            32'(want.sequence_number));
        if (got.time_stamp !== want.time_stamp)
            report_mismatch("time_stamp", got.time_stamp, want.time_stamp);
        if (got.sync_source !== want.sync_source)
            report_mismatch("sync_source", got.sync_source, want.sync_source);
        if (got.word_value !== want.word_value)
            report_mismatch("word_value", got.word_value, want.word_value);
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
    endtask

    // packet assembly
    task automatic push_random(input int unsigned n);
        logic [7:0] v;
        repeat (n) begin
            v = 8'($urandom);
            append_byte(v);
        end
    endtask

    task automatic push_header(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] fill);
        append_byte(b0);
        append_byte(b1);
        repeat (rtp_pkg::HDR_BYTES - 2) append_byte(fill);
    endtask

    task automatic send_packet();
        wire_byte_t w;
        for (int i = 0; i < pkt_build.size(); i++) begin
            w.data = pkt_build[i];
            w.last = (i == pkt_build.size() - 1);
            byte_queue = {byte_queue, w};
        end
        bytes_sent += pkt_build.size();
        pkt_build.delete();
    endtask

    task automatic random_packet();
        int unsigned shape;
        int unsigned roll;
        int unsigned body_len;
        int unsigned cut;
        logic [15:0] ext_len;
        logic [7:0]  b0;
        logic [7:0]  pad;
        shape = $urandom_range(99);
        if (shape < 8) begin
            // noise: random bytes, random length
            push_random($urandom_range(1, 30));
        end else begin
            b0 = 8'($urandom);
            if ($urandom_range(9) != 0) b0[7:6] = 2'd2;
            b0[3:0] = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
                                                 4'($urandom_range(2));
            append_byte(b0);
            push_random(rtp_pkg::HDR_BYTES - 1);
            push_random(4 * b0[3:0]);
            if (b0[4]) begin
                ext_len = ($urandom_range(4) == 0) ? 16'($urandom_range(10)) :
                                                     16'($urandom_range(3));
                push_random(2);
                append_byte(ext_len[15:8]);
                append_byte(ext_len[7:0]);
                push_random(4 * ext_len);
            end
            body_len = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 40);
            push_random(body_len);
            if (b0[5] && body_len != 0) begin
                roll = $urandom_range(99);
                if (roll < 75) pad = 8'($urandom_range(1, body_len));
                else if (roll < 88) pad = 8'h00;
                else pad = 8'($urandom_range(body_len + 1, 255));
                pkt_build[pkt_build.size() - 1] = pad;
            end
            if (shape < 18 && pkt_build.size() > 1) begin
                cut = $urandom_range(1, pkt_build.size() - 1);
                while (pkt_build.size() > cut) void'(pkt_build.pop_back());
            end
        end
        send_packet();
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_valid || result_queue.size() != 0)
            @(posedge aclk);
    endtask

    // byte driver
    always @(negedge aclk) begin : drive
        wire_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_wait <= 0;
        end else if (s_valid && !in_fire) begin
            // hold until the transfer happens
        end else if (src_wait != 0) begin
            s_valid <= 1'b0;
            src_wait <= src_wait - 1;
        end else if (byte_queue.size() != 0) begin
            nxt = byte_queue.pop_front();
            s_data_byte <= nxt.data;
            s_last_byte <= nxt.last;
            s_valid <= 1'b1;
            src_wait <= src_idle ? pick_gap() : 0;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result sink
    always @(negedge aclk) begin
        if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            sink_wait <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (sink_wait != 0) begin
            m_ready <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else begin
            m_ready <= 1'b1;
            sink_wait <= sink_idle ? pick_gap() : 0;
        end
    end

    // monitor
    always @(posedge aclk) begin : watch
        rtp_pkg::rtp_result_t seen;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) decode_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                seen.kind = m_kind;
                seen.version = m_version;
                seen.has_padding = m_has_padding;
                seen.has_extension = m_has_extension;
                seen.csrc_count = m_csrc_count;
                seen.marker = m_marker;
                seen.payload_type = m_payload_type;
                seen.sequence_number = m_sequence_number;
                seen.time_stamp = m_time_stamp;
                seen.sync_source = m_sync_source;
                seen.word_value = m_word_value;
                seen.status = m_status;
                if (result_queue.size() == 0)
                    report_mismatch("unexpected result, kind", 32'(m_kind), 32'd0);
                else
                    check_result(seen);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned target;
        clear_packet();
        final_byte = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: header extremes, header and end in one byte
        push_header(8'h80, 8'h00, 8'h00);
        send_packet();
        push_header(8'hFF, 8'hFF, 8'hFF);
        send_packet();
        append_byte(8'h80);
        send_packet();
        // ends inside the CSRC list
        push_header(8'h82, 8'h7F, 8'h5A);
        push_random(5);
        send_packet();
        // last byte completes a CSRC word
        push_header(8'h81, 8'h80, 8'hA5);
        push_random(4);
        send_packet();
        // full CSRC list, empty extension, short payload
        push_header(8'h9F, 8'h60, 8'h3C);
        push_random(60);
        append_byte(8'hBE);
        append_byte(8'hDE);
        append_byte(8'h00);
        append_byte(8'h00);
        push_random(3);
        send_packet();
        // last byte completes an extension word
        push_header(8'h90, 8'h11, 8'h22);
        append_byte(8'h12);
        append_byte(8'h34);
        append_byte(8'h00);
        append_byte(8'h02);
        push_random(8);
        send_packet();
        // ends right after the extension header while words are due
        push_header(8'h10, 8'h22, 8'h33);
        append_byte(8'hFF);
        append_byte(8'hFF);
        append_byte(8'h00);
        append_byte(8'h01);
        send_packet();
        // padding: good, zero, too large, empty payload, single byte
        push_header(8'hA0, 8'h01, 8'h44);
        push_random(3);
        append_byte(8'h04);
        send_packet();
        push_header(8'hA0, 8'h02, 8'h55);
        push_random(2);
        append_byte(8'h00);
        send_packet();
        push_header(8'hA0, 8'h03, 8'h66);
        push_random(2);
        append_byte(8'h04);
        send_packet();
        push_header(8'hA0, 8'h04, 8'h77);
        send_packet();
        push_header(8'hE0, 8'h05, 8'h88);
        append_byte(8'h01);
        send_packet();
        push_header(8'h40, 8'hC8, 8'h99);
        push_random(4);
        send_packet();
        push_header(8'h00, 8'h7F, 8'hEE);
        push_random(2);
        send_packet();
        wait_idle();

        // random traffic with idling on both sides
        src_idle = 1'b1;
        sink_idle = 1'b1;
        target = bytes_sent + 800;
        while (bytes_sent < target) random_packet();
        wait_idle();

        // back-to-back stretch
        src_idle = 1'b0;
        sink_idle = 1'b0;
        target = bytes_sent + 200;
        while (bytes_sent < target) random_packet();
        wait_idle();

        // sink stalls for a long stretch while bytes keep coming
        target = bytes_sent + 250;
        while (bytes_sent < target) random_packet();
        hold_token = hold_token + 1;
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (result_queue.size() != 0)
            report_mismatch("results never seen, count", 32'(result_queue.size()), 32'd0);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rtp_pkg.sv
rtl/rtp_fifo.sv
rtl/rtp_front.sv
rtl/rtp_back.sv
rtl/rtp_header_parser.sv
dv/testbench.sv
